### design/lsa_pkg.sv
// shared types and constants of the lidar sector avoidance block
`timescale 1ns / 1ps

package lsa_pkg;

  // fixed field widths
  localparam int RANGE_W  = 16;
  localparam int WIDTH_W  = 13;
  localparam int STR_W    = 12;
  localparam int TOTAL_W  = 28;
  localparam int HITS_W   = 13;
  localparam int PROD_W   = 44;
  localparam int CROSS_W  = TOTAL_W + HITS_W;
  localparam int DIV_N_W  = 28;
  localparam int ROLL_W   = 13;
  localparam int YAW_W    = 9;
  localparam int RMAG_W   = 12;
  localparam int YMAG_W   = 8;

  // no-return samples and saturation limits
  localparam logic [RANGE_W-1:0] NO_RETURN_MM = 16'd10000;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = 28'hFFF_FFFF;
  localparam logic [HITS_W-1:0]  HITS_MAX     = 13'd8191;

  // register reset values
  localparam logic [WIDTH_W-1:0] SCAN_WIDTH_RST  = 13'd512;
  localparam logic [RANGE_W-1:0] DETECT_RST      = 16'd3000;
  localparam logic [RANGE_W-1:0] CRITICAL_RST    = 16'd800;
  localparam logic [STR_W-1:0]   STRENGTH_RST    = 12'd384;

  // register indexes on the config port
  localparam logic [1:0] REG_SCAN_WIDTH = 2'd0;
  localparam logic [1:0] REG_DETECT     = 2'd1;
  localparam logic [1:0] REG_CRITICAL   = 2'd2;
  localparam logic [1:0] REG_STRENGTH   = 2'd3;

  typedef struct packed {
    logic [WIDTH_W-1:0] scan_width;
    logic [RANGE_W-1:0] detect_mm;
    logic [RANGE_W-1:0] critical_mm;
    logic [STR_W-1:0]   strength_q8;
  } cfg_t;

  // shared multiplier operand select
  typedef enum logic [1:0] {
    MUL_LEFT_X   = 2'd0,
    MUL_RIGHT_X  = 2'd1,
    MUL_STRENGTH = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     acc;
    logic     check;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_start;
    logic     div_yaw;
    logic     cap_roll;
    logic     cap_yaw;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic avoid_case;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### design/lidar_sector_avoidance.sv
// top level: config registers, controller and datapath of the sector avoidance block
// a sample beat is taken every cycle while the block gathers a scan
// on the scan-end beat: the result passes check and finish when clear or critical;
//   avoiding adds three products and two 28-step restoring divisions on one divider
// no sample is taken from the scan-end beat until the result is loaded
// rst is synchronous: registers return to their defaults, accumulators clear
`timescale 1ns / 1ps

module lidar_sector_avoidance #(
  parameter int MAX_SCAN = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // sample channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] range_mm,
  input  logic        no_return,
  input  logic        scan_end,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hard_stop,
  output logic        avoiding,
  output logic signed [12:0] avoid_roll,
  output logic signed [8:0]  avoid_yaw,
  output logic [15:0] closest_mm
);
  import lsa_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_width  <= SCAN_WIDTH_RST;
      cfg.detect_mm   <= DETECT_RST;
      cfg.critical_mm <= CRITICAL_RST;
      cfg.strength_q8 <= STRENGTH_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SCAN_WIDTH: cfg.scan_width  <= pwdata[WIDTH_W-1:0];
        REG_DETECT:     cfg.detect_mm   <= pwdata[RANGE_W-1:0];
        REG_CRITICAL:   cfg.critical_mm <= pwdata[RANGE_W-1:0];
        REG_STRENGTH:   cfg.strength_q8 <= pwdata[STR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      REG_SCAN_WIDTH: prdata = 32'(cfg.scan_width);
      REG_DETECT:     prdata = 32'(cfg.detect_mm);
      REG_CRITICAL:   prdata = 32'(cfg.critical_mm);
      REG_STRENGTH:   prdata = 32'(cfg.strength_q8);
      default:        prdata = '0;
    endcase
  end

  lsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .scan_end (scan_end),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lsa_datapath #(
    .MAX_SCAN (MAX_SCAN)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg           (cfg),
    .range_mm      (range_mm),
    .no_return     (no_return),
    .scan_end      (scan_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hard_stop     (hard_stop),
    .avoiding      (avoiding),
    .avoid_roll    (avoid_roll),
    .avoid_yaw     (avoid_yaw),
    .closest_mm    (closest_mm)
  );

endmodule

### design/lsa_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lsa_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lsa_pkg::DIV_N_W-1:0] num,
  input  logic [lsa_pkg::RANGE_W-1:0] den,
  output logic                        done,
  output logic [lsa_pkg::DIV_N_W-1:0] quo
);
  import lsa_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_N_W - 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [RANGE_W-1:0] rem;
  logic [RANGE_W:0]   trial;
  logic [RANGE_W:0]   diff;
  logic               ge;

  // one trial subtraction per step
  assign trial = {rem, quo[DIV_N_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      rem <= ge ? diff[RANGE_W-1:0] : trial[RANGE_W-1:0];
      quo <= {quo[DIV_N_W-2:0], ge};
    end
  end

endmodule

### design/lsa_datapath.sv
// accumulators, shared multiplier, divider and result register
`timescale 1ns / 1ps

module lsa_datapath #(
  parameter int MAX_SCAN = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lsa_pkg::cmd_t                cmd,
  output lsa_pkg::status_t             status,
  input  lsa_pkg::cfg_t                cfg,
  input  logic [lsa_pkg::RANGE_W-1:0]  range_mm,
  input  logic                         no_return,
  input  logic                         scan_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hard_stop,
  output logic                         avoiding,
  output logic signed [lsa_pkg::ROLL_W-1:0] avoid_roll,
  output logic signed [lsa_pkg::YAW_W-1:0]  avoid_yaw,
  output logic [lsa_pkg::RANGE_W-1:0]  closest_mm
);
  import lsa_pkg::*;

  localparam int IDX_W = $clog2(MAX_SCAN);
  localparam int CMP_W = (IDX_W > WIDTH_W - 1) ? IDX_W : WIDTH_W - 1;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SCAN - 1);

  logic [IDX_W-1:0]   sample_index;
  logic [RANGE_W-1:0] closest_range;
  logic [TOTAL_W-1:0] left_total, right_total;
  logic [HITS_W-1:0]  left_hits, right_hits;

  logic [RANGE_W-1:0] v;
  logic               hit, in_right;
  logic [TOTAL_W:0]   left_added, right_added;

  logic               crit_r, avoid_r;
  logic [CROSS_W-1:0] cross_l, cross_r;
  logic [TOTAL_W-1:0] prod_s;
  logic [RMAG_W-1:0]  rmag;
  logic [YMAG_W-1:0]  ymag;

  logic [TOTAL_W-1:0] ln, rn;
  logic [HITS_W-1:0]  ld, rd;
  logic [RANGE_W-1:0] diff;
  logic [TOTAL_W-1:0] mul_a;
  logic [RANGE_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [DIV_N_W-1:0] div_num;
  logic [DIV_N_W-1:0] div_quo;
  logic               div_done;
  logic               left_less;

  // sample conditioning and sector split
  assign v        = no_return ? NO_RETURN_MM : range_mm;
  assign hit      = v < cfg.detect_mm;
  assign in_right = CMP_W'(sample_index) < CMP_W'(cfg.scan_width[WIDTH_W-1:1]);
  assign left_added  = {1'b0, left_total} + (TOTAL_W+1)'(v);
  assign right_added = {1'b0, right_total} + (TOTAL_W+1)'(v);

  // scan accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      sample_index  <= '0;
      closest_range <= '1;
      left_total    <= '0;
      right_total   <= '0;
      left_hits     <= '0;
      right_hits    <= '0;
    end else if (cmd.acc) begin
      if (v < closest_range) begin
        closest_range <= v;
      end
      if (hit && in_right) begin
        right_total <= right_added[TOTAL_W] ? TOTAL_MAX : right_added[TOTAL_W-1:0];
        if (right_hits != HITS_MAX) begin
          right_hits <= right_hits + 1'b1;
        end
      end
      if (hit && !in_right) begin
        left_total <= left_added[TOTAL_W] ? TOTAL_MAX : left_added[TOTAL_W-1:0];
        if (left_hits != HITS_MAX) begin
          left_hits <= left_hits + 1'b1;
        end
      end
      if (!scan_end && sample_index != IDX_MAX) begin
        sample_index <= sample_index + 1'b1;
      end
    end
  end

  // sector averages as fractions, empty sector reads as the no-return range
  assign ln   = (left_hits != '0) ? left_total : TOTAL_W'(NO_RETURN_MM);
  assign ld   = (left_hits != '0) ? left_hits : HITS_W'(1);
  assign rn   = (right_hits != '0) ? right_total : TOTAL_W'(NO_RETURN_MM);
  assign rd   = (right_hits != '0) ? right_hits : HITS_W'(1);
  assign diff = cfg.detect_mm - closest_range;

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MUL_LEFT_X: begin
        mul_a = ln;
        mul_b = RANGE_W'(rd);
      end
      MUL_RIGHT_X: begin
        mul_a = rn;
        mul_b = RANGE_W'(ld);
      end
      MUL_STRENGTH: begin
        mul_a = TOTAL_W'(diff);
        mul_b = RANGE_W'(cfg.strength_q8);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // product registers
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_LEFT_X:   cross_l <= mul_p[CROSS_W-1:0];
        MUL_RIGHT_X:  cross_r <= mul_p[CROSS_W-1:0];
        MUL_STRENGTH: prod_s  <= mul_p[TOTAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // rounded dividends for the roll and yaw magnitudes
  assign div_num = cmd.div_yaw
    ? DIV_N_W'({diff, 7'b0}) + DIV_N_W'(cfg.detect_mm[RANGE_W-1:1])
    : prod_s + DIV_N_W'(cfg.detect_mm[RANGE_W-1:1]);

  lsa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (cfg.detect_mm),
    .done  (div_done),
    .quo   (div_quo)
  );

  // decision flags and magnitudes
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      crit_r  <= (closest_range < cfg.detect_mm) && (closest_range < cfg.critical_mm);
      avoid_r <= status.avoid_case;
    end
    if (cmd.cap_roll) begin
      rmag <= div_quo[RMAG_W-1:0];
    end
    if (cmd.cap_yaw) begin
      ymag <= div_quo[YMAG_W-1:0];
    end
  end

  assign left_less = cross_l < cross_r;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hard_stop     <= crit_r;
      avoiding      <= avoid_r;
      closest_mm    <= closest_range;
      if (!avoid_r) begin
        avoid_roll <= '0;
        avoid_yaw  <= '0;
      end else if (left_less) begin
        avoid_roll <= ROLL_W'(rmag);
        avoid_yaw  <= YAW_W'(0) - YAW_W'(ymag);
      end else begin
        avoid_roll <= ROLL_W'(0) - ROLL_W'(rmag);
        avoid_yaw  <= YAW_W'(ymag);
      end
    end
  end

  // status to the controller
  assign status.avoid_case = (closest_range < cfg.detect_mm) &&
                             !(closest_range < cfg.critical_mm);
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid || out_ready;

endmodule

### design/lsa_ctrl.sv
// sequencing controller for sample intake and end-of-scan evaluation
`timescale 1ns / 1ps

module lsa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             scan_end,
  output logic             in_ready,
  input  lsa_pkg::status_t status,
  output lsa_pkg::cmd_t    cmd
);
  import lsa_pkg::*;

  typedef enum logic [9:0] {
    ST_ACC    = 10'b00_0000_0001,
    ST_CHECK  = 10'b00_0000_0010,
    ST_MUL_L  = 10'b00_0000_0100,
    ST_MUL_R  = 10'b00_0000_1000,
    ST_MUL_S  = 10'b00_0001_0000,
    ST_RSTART = 10'b00_0010_0000,
    ST_RWAIT  = 10'b00_0100_0000,
    ST_YSTART = 10'b00_1000_0000,
    ST_YWAIT  = 10'b01_0000_0000,
    ST_FINISH = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_ACC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MUL_LEFT_X;
    case (state)
      ST_ACC: begin
        cmd.acc = in_valid;
        if (in_valid && scan_end) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.avoid_case ? ST_MUL_L : ST_FINISH;
      end
      ST_MUL_L: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LEFT_X;
        state_next  = ST_MUL_R;
      end
      ST_MUL_R: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RIGHT_X;
        state_next  = ST_MUL_S;
      end
      ST_MUL_S: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_STRENGTH;
        state_next  = ST_RSTART;
      end
      ST_RSTART: begin
        cmd.div_start = 1'b1;
        state_next    = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (status.div_done) begin
          cmd.cap_roll = 1'b1;
          state_next   = ST_YSTART;
        end
      end
      ST_YSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_yaw   = 1'b1;
        state_next    = ST_YWAIT;
      end
      ST_YWAIT: begin
        if (status.div_done) begin
          cmd.cap_yaw = 1'b1;
          state_next  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_ACC;
        end
      end
      default: begin
        state_next = ST_ACC;
      end
    endcase
  end

endmodule

### design/lsa_checker.sv
// port-level assertions for the sector avoidance block, bound to the top level
`timescale 1ns / 1ps

module lsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        scan_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hard_stop,
  input logic        avoiding,
  input logic signed [12:0] avoid_roll,
  input logic signed [8:0]  avoid_yaw,
  input logic [15:0] closest_mm
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(closest_mm) &&
      $stable(avoid_roll) && $stable(avoid_yaw))
    else $error("stalled result beat changed");

  // critical stop and avoidance never together
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hard_stop && avoiding))
    else $error("critical stop with avoidance");

  // no push without avoidance
  a_no_push: assert property (@(posedge clk) disable iff (rst)
    out_valid && !avoiding |-> avoid_roll == 13'sd0 && avoid_yaw == 9'sd0)
    else $error("push without avoidance");

  // a mid-scan sample beat keeps the block ready for the next one
  a_stream: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !scan_end |=> in_ready)
    else $error("intake stalled mid-scan");

endmodule

bind lidar_sector_avoidance lsa_checker u_lsa_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .scan_end      (scan_end),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .hard_stop     (hard_stop),
  .avoiding      (avoiding),
  .avoid_roll    (avoid_roll),
  .avoid_yaw     (avoid_yaw),
  .closest_mm    (closest_mm)
);

### test/testbench.sv
// self-checking testbench for the lidar sector avoidance block
`timescale 1ns / 1ps

module testbench;
  import lsa_pkg::*;

  localparam int SCAN_CAP    = 4096;
  localparam int SETTLE      = 80;
  localparam int HOLD_CYCLES = 400;

  // one avoidance command as it leaves the block
  typedef struct {
    logic              hard_stop;
    logic              avoiding;
    logic signed [12:0] roll;
    logic signed [8:0]  yaw;
    logic [15:0]       closest;
  } avoid_cmd_t;

  // tracks the scan, predicts each command and checks the block against it
  class avoidance_scoreboard;
    int unsigned scan_width, detect, critical, strength;
    int unsigned index, closest, left_hits, right_hits;
    longint unsigned left_total, right_total;
    avoid_cmd_t awaited_cmds[$];
    int failures;

    function new();
      scan_width = SCAN_WIDTH_RST;
      detect     = DETECT_RST;
      critical   = CRITICAL_RST;
      strength   = STRENGTH_RST;
      failures   = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      index       = 0;
      closest     = 32'hFFFF;
      left_total  = 0;
      right_total = 0;
      left_hits   = 0;
      right_hits  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, int unsigned val);
      case (idx)
        REG_SCAN_WIDTH: scan_width = val[12:0];
        REG_DETECT:     detect = val[15:0];
        REG_CRITICAL:   critical = val[15:0];
        REG_STRENGTH:   strength = val[11:0];
        default: ;
      endcase
    endfunction

    function bit empty();
      return awaited_cmds.size() == 0;
    endfunction

    // accepted sample beat: update the sector sums, predict a command on scan end
    function void take_sample(logic [15:0] r, logic nr, logic last);
      int unsigned v, mid, diff, rmag, ymag;
      longint unsigned lnum, lden, rnum, rden;
      avoid_cmd_t cmd;
      v = nr ? int'(NO_RETURN_MM) : r;
      mid = scan_width / 2;
      if (v < closest) closest = v;
      if (v < detect) begin
        if (index < mid) begin
          right_total = (right_total + v > TOTAL_MAX) ? TOTAL_MAX : right_total + v;
          if (right_hits < HITS_MAX) right_hits++;
        end else begin
          left_total = (left_total + v > TOTAL_MAX) ? TOTAL_MAX : left_total + v;
          if (left_hits < HITS_MAX) left_hits++;
        end
      end
      if (!last) begin
        if (index < SCAN_CAP - 1) index++;
        return;
      end
      cmd.hard_stop     = 1'b0;
      cmd.avoiding      = 1'b0;
      cmd.roll          = '0;
      cmd.yaw           = '0;
      cmd.closest       = closest[15:0];
      if (closest < detect) begin
        if (closest < critical) begin
          cmd.hard_stop = 1'b1;
        end else begin
          // empty sector averages 10000; compare averages by cross-multiplying
          lnum = left_hits ? left_total : NO_RETURN_MM;
          lden = left_hits ? left_hits : 1;
          rnum = right_hits ? right_total : NO_RETURN_MM;
          rden = right_hits ? right_hits : 1;
          diff = detect - closest;
          rmag = 32'((64'(strength) * diff + detect / 2) / detect);
          ymag = 32'((64'(128) * diff + detect / 2) / detect);
          cmd.avoiding = 1'b1;
          if (lnum * rden < rnum * lden) begin
            cmd.roll = 13'(rmag);
            cmd.yaw  = 9'(0 - ymag);
          end else begin
            cmd.roll = 13'(0 - rmag);
            cmd.yaw  = 9'(ymag);
          end
        end
      end
      awaited_cmds.push_back(cmd);
      clear_scan();
    endfunction

    // result beat: compare with the oldest predicted command
    function void check_command(avoid_cmd_t got);
      avoid_cmd_t want;
      if (awaited_cmds.size() == 0) begin
        $error("result beat with no command pending");
        failures++;
        return;
      end
      want = awaited_cmds.pop_front();
      if (got.hard_stop !== want.hard_stop) begin
        $error("hard_stop: expected %0d, got %0d", want.hard_stop, got.hard_stop);
        failures++;
      end
      if (got.avoiding !== want.avoiding) begin
        $error("avoiding: expected %0d, got %0d", want.avoiding, got.avoiding);
        failures++;
      end
      if (got.roll !== want.roll) begin
        $error("avoid_roll: expected %0d, got %0d", want.roll, got.roll);
        failures++;
      end
      if (got.yaw !== want.yaw) begin
        $error("avoid_yaw: expected %0d, got %0d", want.yaw, got.yaw);
        failures++;
      end
      if (got.closest !== want.closest) begin
        $error("closest_mm: expected %0d, got %0d", want.closest, got.closest);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  logic [15:0] range_mm;
  logic no_return, scan_end;
  logic out_valid, out_ready;
  logic hard_stop, avoiding;
  logic signed [12:0] avoid_roll;
  logic signed [8:0] avoid_yaw;
  logic [15:0] closest_mm;

  bit calm;
  bit hold_request;
  avoid_cmd_t seen;
  avoidance_scoreboard sb = new();

  lidar_sector_avoidance #(.MAX_SCAN(SCAN_CAP)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .range_mm(range_mm), .no_return(no_return), .scan_end(scan_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .hard_stop(hard_stop), .avoiding(avoiding),
    .avoid_roll(avoid_roll), .avoid_yaw(avoid_yaw), .closest_mm(closest_mm)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // result beats go to the scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.hard_stop     = hard_stop;
      seen.avoiding      = avoiding;
      seen.roll          = avoid_roll;
      seen.yaw           = avoid_yaw;
      seen.closest       = closest_mm;
      sb.check_command(seen);
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one register write: setup then access
  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // one sample beat, with an occasional gap in front
  task automatic send_sample(input logic [15:0] r, input logic nr, input logic last);
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    range_mm  <= r;
    no_return <= nr;
    scan_end  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_sample(r, nr, last);
  endtask

  // stop sending and wait for every pending command
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (!sb.empty()) @(posedge clk);
  endtask

  // idle block, then a new register set
  task automatic configure(input int unsigned sw, input int unsigned det,
                           input int unsigned crit, input int unsigned str);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_SCAN_WIDTH, sw);
    write_reg(REG_DETECT, det);
    write_reg(REG_CRITICAL, crit);
    write_reg(REG_STRENGTH, str);
  endtask

  // ranges biased toward the thresholds
  function automatic logic [15:0] pick_range(int det, int crit);
    int v;
    case ($urandom_range(0, 7))
      0, 1: v = $urandom_range(0, 65535);
      2: v = det + int'($urandom_range(0, 40)) - 20;
      3: v = crit + int'($urandom_range(0, 40)) - 20;
      default: v = (crit < det) ? int'($urandom_range(crit, det)) : int'($urandom_range(0, det));
    endcase
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // random scans under one register set; pause_at < 0 means no drain midway
  task automatic run_phase(input int sw, input int det, input int crit, input int str,
                           input int n_items, input int pause_at);
    int sent;
    int len;
    configure(sw, det, crit, str);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) len = (sw < 1) ? 1 : (sw > 64 ? 64 : sw);
      else len = $urandom_range(1, 24);
      for (int k = 0; k < len; k++) begin
        if (sent == pause_at) drain_results();
        send_sample(pick_range(det, crit), $urandom_range(0, 9) == 0, k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    int sw, det, crit;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    range_mm     = '0;
    no_return    = 1'b0;
    scan_end     = 1'b0;
    calm         = 1'b0;
    hold_request = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single-sample scans at the reset settings
    send_sample(16'd0, 1'b0, 1'b1);       // critical
    send_sample(16'd799, 1'b0, 1'b1);     // just under critical
    send_sample(16'd800, 1'b0, 1'b1);     // critical bound, avoidance only
    send_sample(16'd2999, 1'b0, 1'b1);    // just under detect
    send_sample(16'd3000, 1'b0, 1'b1);    // no obstacle
    send_sample(16'hFFFF, 1'b0, 1'b1);    // max range
    send_sample(16'h1234, 1'b1, 1'b1);    // no return
    send_sample(16'd0, 1'b1, 1'b1);       // no return masks a zero range

    // four-sample scans: two per sector
    configure(4, 3000, 800, 384);
    // long receiver hold-off while these scans keep coming
    hold_request = 1'b1;
    // right closer: steer left
    send_sample(16'd1000, 1'b0, 1'b0);
    send_sample(16'd1000, 1'b0, 1'b0);
    send_sample(16'd2000, 1'b0, 1'b0);
    send_sample(16'd2000, 1'b0, 1'b1);
    // left closer: strafe right
    send_sample(16'd2000, 1'b0, 1'b0);
    send_sample(16'd2000, 1'b0, 1'b0);
    send_sample(16'd1000, 1'b0, 1'b0);
    send_sample(16'd1000, 1'b0, 1'b1);
    // equal averages
    send_sample(16'd1500, 1'b0, 1'b0);
    send_sample(16'd1500, 1'b0, 1'b0);
    send_sample(16'd1500, 1'b0, 1'b0);
    send_sample(16'd1500, 1'b0, 1'b1);
    // empty right sector
    send_sample(16'd5000, 1'b0, 1'b0);
    send_sample(16'd0, 1'b1, 1'b0);
    send_sample(16'd1200, 1'b0, 1'b1);

    run_phase(8, 3000, 800, 384, 120, -1);
    run_phase(2, 65535, 0, 4095, 120, 60);
    run_phase(16, 1, 0, 0, 80, -1);
    run_phase(0, 0, 65535, 1, 60, -1);
    run_phase(1, 500, 65535, 256, 60, -1);
    run_phase(8191, 40000, 20000, 2048, 80, -1);

    repeat (4) begin
      sw   = $urandom_range(2, 64);
      det  = $urandom_range(1, 65535);
      crit = $urandom_range(0, det);
      run_phase(sw, det, crit, $urandom_range(0, 4095), 100, 50);
    end

    // no idling on either side to finish
    calm = 1'b1;
    run_phase(6, 5000, 1000, 384, 100, -1);

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (sb.failures == 0 && sb.empty()) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
